// ----- hw/rtl/gtb_pkg.sv -----
package gtb_pkg;

  localparam int unsigned PT_SPAN = 1024;

  localparam logic [10:0] NONE_MARK = 11'd1024;
  localparam logic [1:0]  MAX_LINKS = 2'd2;

  localparam logic [1:0] ACT_OFFER = 2'd0;
  localparam logic [1:0] ACT_CLOSE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [9:0] point_a;
    logic [9:0] point_b;
  } gtb_in_t;

  typedef struct packed {
    logic        accepted;
    logic        status;
    logic [1:0]  degree;
    logic [10:0] first_neighbor;
    logic [10:0] second_neighbor;
    logic [10:0] path_end;
    logic [10:0] tour_start;
  } gtb_out_t;

  typedef struct packed {
    logic [1:0]  links;
    logic [10:0] nbr_one;
    logic [10:0] nbr_two;
  } gtb_node_t;

  localparam gtb_node_t NODE_CLEAR = '{links: 2'd0, nbr_one: NONE_MARK, nbr_two: NONE_MARK};

  typedef struct packed {
    logic capture;
    logic clear;
    logic rd_look;
    logic rd_end;
    logic eval;
    logic wr_first;
    logic wr_second;
    logic rd_report;
    logic load_out;
  } gtb_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic is_close;
  } gtb_stat_t;

endpackage

// ----- hw/rtl/gtb_if.sv -----
interface gtb_in_if;
  logic              valid;
  logic              ready;
  gtb_pkg::gtb_in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gtb_out_if;
  logic              valid;
  logic              ready;
  gtb_pkg::gtb_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/gtb_ctrl.sv -----
module gtb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  gtb_pkg::gtb_stat_t  stat,
  output gtb_pkg::gtb_cmd_t   cmd
);
  import gtb_pkg::*;

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_LOOK  = 9'b000000100,
    ST_LOOK2 = 9'b000001000,
    ST_EVAL  = 9'b000010000,
    ST_WR1   = 9'b000100000,
    ST_WR2   = 9'b001000000,
    ST_RPT   = 9'b010000000,
    ST_FIN   = 9'b100000000
  } gtb_state_t;

  gtb_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clr_done) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOK;
        end
      end
      ST_LOOK: begin
        cmd.rd_look = 1'b1;
        state_nxt   = stat.is_close ? ST_LOOK2 : ST_EVAL;
      end
      ST_LOOK2: begin
        cmd.rd_end = 1'b1;
        state_nxt  = ST_EVAL;
      end
      ST_EVAL: begin
        cmd.eval  = 1'b1;
        state_nxt = ST_WR1;
      end
      ST_WR1: begin
        cmd.wr_first = 1'b1;
        state_nxt    = ST_WR2;
      end
      ST_WR2: begin
        cmd.wr_second = 1'b1;
        state_nxt     = ST_RPT;
      end
      ST_RPT: begin
        cmd.rd_report = 1'b1;
        state_nxt     = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- hw/rtl/gtb_dp.sv -----
module gtb_dp #(
  parameter int unsigned POINT_COUNT = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gtb_pkg::gtb_cmd_t  cmd,
  output gtb_pkg::gtb_stat_t stat,
  input  gtb_pkg::gtb_in_t   in_data,
  output gtb_pkg::gtb_out_t  out_data
);
  import gtb_pkg::*;

  localparam int unsigned MEM_DEPTH = (POINT_COUNT < PT_SPAN) ? POINT_COUNT : PT_SPAN;
  localparam int unsigned ADDR_W    = $clog2(MEM_DEPTH);

  function automatic logic [ADDR_W-1:0] idx_of(input logic [10:0] p);
    return (32'(p) < MEM_DEPTH) ? p[ADDR_W-1:0] : '0;
  endfunction

  gtb_node_t   node_mem [MEM_DEPTH];
  logic [10:0] far_mem  [MEM_DEPTH];

  logic [1:0]  act_r;
  logic [9:0]  pa_r, pb_r;
  logic [10:0] start_r;
  logic [ADDR_W-1:0] clr_idx_r;

  gtb_node_t   node_rd0_r, node_rd1_r;
  logic [10:0] far_rd0_r, far_rd1_r;

  logic [ADDR_W-1:0] wa_r, wb_r, fa_r, fb_r;
  gtb_node_t         wa_data_r, wb_data_r;
  logic [10:0]       fa_data_r, fb_data_r;
  logic              node_we_r, far_we_r, start_we_r;
  logic [10:0]       start_plan_r;
  logic              acc_r, stat_r;
  gtb_out_t          out_r;

  logic [10:0] pa_ext, pb_ext, ea, eb;
  logic        is_close, is_offer, a_ok, b_ok, ea_v, eb_v, edge_ok, s_v, close_ok;
  gtb_node_t   na, nb, wa_data, wb_data;
  logic [ADDR_W-1:0] wa, wb, fa, fb;
  logic [10:0] fa_data, fb_data;
  logic        node_we, far_we;

  logic [ADDR_W-1:0] rd0_addr, rd1_addr;
  logic              rd0_en, rd1_en;
  logic              nwe, fwe;
  logic [ADDR_W-1:0] nwa, fwa;
  gtb_node_t         nwd;
  logic [10:0]       fwd;

  function automatic gtb_out_t out_data_nxt();
    gtb_out_t o;
    o.accepted   = acc_r;
    o.status     = stat_r;
    o.tour_start = start_r;
    if (a_ok) begin
      o.degree          = node_rd0_r.links;
      o.first_neighbor  = node_rd0_r.nbr_one;
      o.second_neighbor = node_rd0_r.nbr_two;
      o.path_end        = far_rd0_r;
    end else begin
      o.degree          = 2'd0;
      o.first_neighbor  = NONE_MARK;
      o.second_neighbor = NONE_MARK;
      o.path_end        = NONE_MARK;
    end
    return o;
  endfunction

  assign pa_ext   = {1'b0, pa_r};
  assign pb_ext   = {1'b0, pb_r};
  assign is_close = (act_r == ACT_CLOSE);
  assign is_offer = (act_r == ACT_OFFER);
  assign a_ok     = 32'(pa_r) < MEM_DEPTH;
  assign b_ok     = 32'(pb_r) < MEM_DEPTH;
  assign na       = node_rd0_r;
  assign nb       = node_rd1_r;
  assign ea       = far_rd0_r;
  assign eb       = far_rd1_r;
  assign ea_v     = (ea != NONE_MARK);
  assign eb_v     = (eb != NONE_MARK);
  assign s_v      = (start_r != NONE_MARK);

  assign edge_ok  = (pa_r != pb_r) && a_ok && b_ok &&
                    (na.links < MAX_LINKS) && (nb.links < MAX_LINKS) &&
                    (ea != pb_ext) && (eb != pa_ext);
  assign close_ok = s_v && ea_v && (ea != start_r) &&
                    (na.links < MAX_LINKS) && (nb.links < MAX_LINKS);

  always_comb begin
    wa_data       = na;
    wb_data       = nb;
    wa_data.links = na.links + 2'd1;
    wb_data.links = nb.links + 2'd1;
    if (is_close) begin
      wa              = idx_of(start_r);
      wb              = idx_of(ea);
      wa_data.nbr_two = ea;
      wb_data.nbr_two = start_r;
      node_we         = close_ok;
    end else begin
      wa = idx_of(pa_ext);
      wb = idx_of(pb_ext);
      if (ea_v) wa_data.nbr_two = pb_ext;
      else      wa_data.nbr_one = pb_ext;
      if (eb_v) wb_data.nbr_two = pa_ext;
      else      wb_data.nbr_one = pa_ext;
      node_we = is_offer && edge_ok;
    end
    far_we  = is_offer && edge_ok;
    fa      = ea_v ? idx_of(ea) : idx_of(pa_ext);
    fa_data = eb_v ? eb : pb_ext;
    fb      = eb_v ? idx_of(eb) : idx_of(pb_ext);
    fb_data = ea_v ? ea : pa_ext;
  end

  always_comb begin
    rd0_en   = cmd.rd_look | cmd.rd_report;
    rd1_en   = cmd.rd_look | cmd.rd_end;
    rd0_addr = (cmd.rd_look && is_close) ? idx_of(start_r) : idx_of(pa_ext);
    rd1_addr = cmd.rd_look ? idx_of(pb_ext) : idx_of(far_rd0_r);
  end

  always_comb begin
    nwe = cmd.clear | ((cmd.wr_first | cmd.wr_second) & node_we_r);
    fwe = cmd.clear | ((cmd.wr_first | cmd.wr_second) & far_we_r);
    if (cmd.clear) begin
      nwa = clr_idx_r;
      nwd = NODE_CLEAR;
      fwa = clr_idx_r;
      fwd = NONE_MARK;
    end else if (cmd.wr_first) begin
      nwa = wa_r;
      nwd = wa_data_r;
      fwa = fa_r;
      fwd = fa_data_r;
    end else begin
      nwa = wb_r;
      nwd = wb_data_r;
      fwa = fb_r;
      fwd = fb_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (nwe) node_mem[nwa] <= nwd;
    if (fwe) far_mem[fwa] <= fwd;
    if (rd0_en) begin
      node_rd0_r <= node_mem[rd0_addr];
      far_rd0_r  <= far_mem[rd0_addr];
    end
    if (rd1_en) begin
      node_rd1_r <= node_mem[rd1_addr];
      far_rd1_r  <= far_mem[rd1_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_data.action;
      pa_r  <= in_data.point_a;
      pb_r  <= in_data.point_b;
    end
    if (cmd.eval) begin
      wa_r         <= wa;
      wb_r         <= wb;
      wa_data_r    <= wa_data;
      wb_data_r    <= wb_data;
      fa_r         <= fa;
      fb_r         <= fb;
      fa_data_r    <= fa_data;
      fb_data_r    <= fb_data;
      start_plan_r <= ea_v ? ea : pa_ext;
      acc_r        <= node_we;
      stat_r       <= is_close && !s_v;
    end
    if (cmd.load_out) out_r <= out_data_nxt();
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_we_r  <= 1'b0;
      far_we_r   <= 1'b0;
      start_we_r <= 1'b0;
      start_r    <= NONE_MARK;
      clr_idx_r  <= '0;
    end else begin
      if (cmd.eval) begin
        node_we_r  <= node_we;
        far_we_r   <= far_we;
        start_we_r <= far_we;
      end
      if (cmd.wr_second && start_we_r) start_r <= start_plan_r;
      if (cmd.clear) clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign stat.clr_done = (clr_idx_r == ADDR_W'(MEM_DEPTH - 1));
  assign stat.is_close = is_close;
  assign out_data      = out_r;

endmodule

// ----- hw/rtl/greedy_edge_tour_builder_core.sv -----
// Greedy edge tour builder: feed candidate edges shortest first (action offer); each
// item returns one result with the accept flag, the entry of point_a after the step
// and the current tour start. After reset the block sweeps all min(POINT_COUNT,
// 1024) entries of its point store with in_ch.ready low, one entry per cycle. It
// then works one item at a time: lookup (a close adds a far-end read), evaluation,
// the writes through the single write port of the point store (two entries and
// two far-end words written per edge), a report read and the output load. A
// finished result waits in the output register while the next item is taken.
module greedy_edge_tour_builder_core #(
  parameter int unsigned POINT_COUNT = 1024
) (
  input logic       clk,
  input logic       rst_n,
  gtb_in_if.sink    in_ch,
  gtb_out_if.source out_ch
);
  import gtb_pkg::*;

  gtb_cmd_t  cmd;
  gtb_stat_t stat;

  gtb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  gtb_dp #(
    .POINT_COUNT (POINT_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_data  (in_ch.data),
    .out_data (out_ch.data)
  );

`ifndef SYNTHESIS
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("item accepted while previous item still in work");

  a_degree_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.data.degree != 2'd3)
    else $error("link count above two");

  a_accept_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.data.accepted && out_ch.data.status))
    else $error("close applied with no start point");

  a_start_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.data.tour_start == NONE_MARK ||
                      32'(out_ch.data.tour_start) < POINT_COUNT))
    else $error("tour start outside point range");
`endif

endmodule

// ----- sim/tour_store_checker.sv -----
module tour_store_checker (
  input  logic clk,
  input  logic rst_n,
  gtb_in_if    in_mon,
  gtb_out_if   out_mon,
  output int   mismatch_count,
  output int   reports_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import gtb_pkg::*;

  logic [1:0]  links       [PT_SPAN];
  logic [10:0] nbr_first   [PT_SPAN];
  logic [10:0] nbr_second  [PT_SPAN];
  logic [10:0] far_end_of  [PT_SPAN];
  logic [10:0] tour_head;

  gtb_out_t pending_reports [$];
  int       errors;

  function automatic gtb_out_t step_tour(input gtb_in_t item);
    gtb_out_t    rep;
    logic [9:0]  a, b;
    logic [10:0] ea, eb, s, e;
    a   = item.point_a;
    b   = item.point_b;
    rep = '0;
    if (item.action == ACT_OFFER) begin
      ea = far_end_of[a];
      eb = far_end_of[b];
      if (a != b && links[a] < MAX_LINKS && links[b] < MAX_LINKS &&
          ea != {1'b0, b} && eb != {1'b0, a}) begin
        links[a] = links[a] + 2'd1;
        links[b] = links[b] + 2'd1;
        if (ea != NONE_MARK) begin
          nbr_second[a] = {1'b0, b};
          tour_head     = ea;
          if (eb != NONE_MARK) begin
            nbr_second[b]        = {1'b0, a};
            far_end_of[ea[9:0]] = eb;
            far_end_of[eb[9:0]] = ea;
          end else begin
            nbr_first[b]         = {1'b0, a};
            far_end_of[b]        = ea;
            far_end_of[ea[9:0]] = {1'b0, b};
          end
        end else begin
          nbr_first[a] = {1'b0, b};
          tour_head    = {1'b0, a};
          if (eb != NONE_MARK) begin
            nbr_second[b]        = {1'b0, a};
            far_end_of[a]        = eb;
            far_end_of[eb[9:0]] = {1'b0, a};
          end else begin
            nbr_first[b]  = {1'b0, a};
            far_end_of[a] = {1'b0, b};
            far_end_of[b] = {1'b0, a};
          end
        end
        rep.accepted = 1'b1;
      end
    end else if (item.action == ACT_CLOSE) begin
      s = tour_head;
      if (s == NONE_MARK) begin
        rep.status = 1'b1;
      end else begin
        e = far_end_of[s[9:0]];
        if (e != NONE_MARK && e != s && links[s[9:0]] < MAX_LINKS &&
            links[e[9:0]] < MAX_LINKS) begin
          nbr_second[s[9:0]] = e;
          nbr_second[e[9:0]] = s;
          links[s[9:0]]      = links[s[9:0]] + 2'd1;
          links[e[9:0]]      = links[e[9:0]] + 2'd1;
          rep.accepted       = 1'b1;
        end
      end
    end
    rep.degree          = links[a];
    rep.first_neighbor  = nbr_first[a];
    rep.second_neighbor = nbr_second[a];
    rep.path_end        = far_end_of[a];
    rep.tour_start      = tour_head;
    return rep;
  endfunction

  always @(posedge clk) begin
    gtb_out_t got, want;
    if (!rst_n) begin
      for (int i = 0; i < PT_SPAN; i++) begin
        links[i]      = '0;
        nbr_first[i]  = NONE_MARK;
        nbr_second[i] = NONE_MARK;
        far_end_of[i] = NONE_MARK;
      end
      tour_head = NONE_MARK;
      pending_reports.delete();
      errors = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        pending_reports.push_back(step_tour(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (pending_reports.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: result with no item pending: acc=%0d st=%0d deg=%0d n1=%0d n2=%0d end=%0d start=%0d",
                     $time, got.accepted, got.status, got.degree, got.first_neighbor,
                     got.second_neighbor, got.path_end, got.tour_start);
        end else begin
          want = pending_reports.pop_front();
          if (got.accepted !== want.accepted || got.status !== want.status ||
              got.degree !== want.degree || got.first_neighbor !== want.first_neighbor ||
              got.second_neighbor !== want.second_neighbor ||
              got.path_end !== want.path_end || got.tour_start !== want.tour_start) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: mismatch expected acc=%0d st=%0d deg=%0d n1=%0d n2=%0d end=%0d start=%0d",
                       $time, want.accepted, want.status, want.degree, want.first_neighbor,
                       want.second_neighbor, want.path_end, want.tour_start);
              $display("%0t:          actual   acc=%0d st=%0d deg=%0d n1=%0d n2=%0d end=%0d start=%0d",
                       $time, got.accepted, got.status, got.degree, got.first_neighbor,
                       got.second_neighbor, got.path_end, got.tour_start);
            end
          end
        end
      end
    end
    mismatch_count <= errors;
    reports_owed   <= pending_reports.size();
  end

endmodule

// ----- sim/tb_greedy_edge_tour_builder_core.sv -----
module tb_greedy_edge_tour_builder_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gtb_pkg::*;

  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam int         ITEM_GOAL = 1850;

  logic clk = 1'b0;
  logic rst_n;

  int         in_idle_pct;
  int         out_stall_pct;
  int         items_sent;
  int         mismatch_count;
  int         reports_owed;
  int         pool_pos;
  bit         touched    [PT_SPAN];
  logic [9:0] fresh_pool [PT_SPAN];

  gtb_in_if  in_ch ();
  gtb_out_if out_ch ();

  greedy_edge_tour_builder_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  tour_store_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .reports_owed   (reports_owed)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic gtb_in_t make_item(input logic [1:0] act, input logic [9:0] a,
                                        input logic [9:0] b);
    gtb_in_t item;
    item.action  = act;
    item.point_a = a;
    item.point_b = b;
    return item;
  endfunction

  function automatic logic [9:0] take_fresh();
    while (pool_pos < PT_SPAN && touched[fresh_pool[pool_pos]])
      pool_pos++;
    if (pool_pos >= PT_SPAN)
      return 10'($urandom_range(0, PT_SPAN - 1));
    pool_pos++;
    return fresh_pool[pool_pos - 1];
  endfunction

  task automatic send_item(input gtb_in_t item);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    if (item.action == ACT_OFFER) begin
      touched[item.point_a] = 1'b1;
      touched[item.point_b] = 1'b1;
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    @(posedge clk);
    while (!in_ch.ready)
      @(posedge clk);
    items_sent++;
  endtask

  task automatic build_tour(input int k);
    logic [9:0] pts [$];
    for (int i = 0; i < k; i++)
      pts.push_back(take_fresh());
    if ($urandom_range(0, 1)) begin
      for (int i = 0; i + 1 < k; i++) begin
        if ($urandom_range(0, 1))
          send_item(make_item(ACT_OFFER, pts[i], pts[i + 1]));
        else
          send_item(make_item(ACT_OFFER, pts[i + 1], pts[i]));
      end
    end
    repeat ($urandom_range(k, 2 * k))
      send_item(make_item(ACT_OFFER, pts[$urandom_range(0, k - 1)],
                          pts[$urandom_range(0, k - 1)]));
    repeat ($urandom_range(1, 2))
      send_item(make_item(ACT_CLOSE, pts[$urandom_range(0, k - 1)], 10'($urandom)));
    repeat ($urandom_range(0, 3))
      send_item(make_item(ACT_READ, pts[$urandom_range(0, k - 1)], 10'($urandom)));
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(0, 99) >= out_stall_pct);
    end
  end

  initial begin
    int         pick;
    logic [9:0] swap;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.data    <= '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    items_sent    = 0;
    pool_pos      = 0;
    for (int i = 0; i < PT_SPAN; i++)
      fresh_pool[i] = 10'(i);
    for (int i = PT_SPAN - 1; i > 0; i--) begin
      pick             = $urandom_range(0, i);
      swap             = fresh_pool[i];
      fresh_pool[i]    = fresh_pool[pick];
      fresh_pool[pick] = swap;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_item(make_item(ACT_CLOSE, 10'd0, 10'd0));
    send_item(make_item(ACT_READ, 10'd1023, 10'd0));
    send_item(make_item(ACT_SPARE, 10'd512, 10'd1023));
    send_item(make_item(ACT_OFFER, 10'd7, 10'd7));
    send_item(make_item(ACT_OFFER, 10'd0, 10'd1023));
    send_item(make_item(ACT_OFFER, 10'd1023, 10'd0));
    send_item(make_item(ACT_OFFER, 10'd1, 10'd2));
    send_item(make_item(ACT_OFFER, 10'd0, 10'd1));
    send_item(make_item(ACT_READ, 10'd0, 10'd1023));
    send_item(make_item(ACT_CLOSE, 10'd1023, 10'd0));
    send_item(make_item(ACT_CLOSE, 10'd2, 10'd0));
    send_item(make_item(ACT_OFFER, 10'd2, 10'd5));
    send_item(make_item(ACT_OFFER, 10'd5, 10'd6));
    send_item(make_item(ACT_OFFER, 10'd6, 10'd1023));
    send_item(make_item(ACT_OFFER, 10'd3, 10'd4));
    send_item(make_item(ACT_OFFER, 10'd5, 10'd4));
    send_item(make_item(ACT_OFFER, 10'd6, 10'd8));
    send_item(make_item(ACT_OFFER, 10'd9, 10'd8));
    send_item(make_item(ACT_CLOSE, 10'd9, 10'd0));
    send_item(make_item(ACT_READ, 10'd9, 10'd0));
    send_item(make_item(ACT_SPARE, 10'd1023, 10'd1023));

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          in_idle_pct   = 0;
          out_stall_pct = 0;
        end
        1: begin
          in_idle_pct   = 58;
          out_stall_pct = 0;
        end
        2: begin
          in_idle_pct   = 0;
          out_stall_pct = 58;
        end
        default: begin
          in_idle_pct   = 34;
          out_stall_pct = 34;
        end
      endcase
      while (items_sent < ITEM_GOAL * (phase + 1) / 4) begin
        if ($urandom_range(0, 99) < 15)
          send_item(make_item(2'($urandom_range(0, 3)), 10'($urandom), 10'($urandom)));
        else if ($urandom_range(0, 9) == 0)
          build_tour($urandom_range(13, 40));
        else
          build_tour($urandom_range(3, 12));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (reports_owed != 0)
      @(posedge clk);
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && reports_owed == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
